[design/icm_pkg.sv]
// shared constants, request tag type and channel color functions of the color mapper
// no dependencies
`default_nettype none

package icm_pkg;

   // default sizes handed to the top level parameters
   localparam int DEF_COUNT_WIDTH = 16;
   localparam int DEF_MAX_PALETTE = 4096;
   localparam int DEF_SINE_DEPTH  = 1024;

   // register widths and indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int LEN_W       = 13;
   localparam int MODE_W      = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ITER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL_LEN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL_MODE = 2'd2;

   // register reset values
   localparam logic [15:0]       RST_MAX_ITER = 16'd100;
   localparam logic [LEN_W-1:0]  RST_PAL_LEN  = 13'd256;
   localparam logic [MODE_W-1:0] RST_PAL_MODE = 3'd0;

   // palette modes, codes above oceanic act as inverted rainbow
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GRAY    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUNSET  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_OCEAN   = 3'd3;

   // phase constants in Q0.16 turns
   localparam logic [15:0] THIRD_TURN      = 16'd21845;
   localparam logic [15:0] TWO_THIRDS_TURN = 16'd43691;
   localparam logic [15:0] HALF_TURN       = 16'd32768;

   // 0.3 in Q0.16 and pi in Q2.30
   localparam int OCEAN_AMP = 19661;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // control that travels with a request through the pipeline
   typedef struct packed {
      logic valid;
      logic in_set;
   } icm_tag_type;

   // 255 * (32768 + s) >> 16
   function automatic logic [7:0] wave_half(input logic signed [15:0] s);
      logic [15:0] v;
      logic [23:0] m;
      v = {~s[15], s[14:0]};
      m = {v, 8'd0} - 24'(v);
      return m[23:16];
   endfunction

   // 255 * (0.3 * s + 0.5) in fixed point
   function automatic logic [7:0] wave_ocean(input logic signed [15:0] s);
      logic signed [31:0] q;
      logic [38:0]        m;
      q = 32'(32'(signed'(OCEAN_AMP)) * 32'(s)) + 32'sd1073741824;
      m = {q[30:0], 8'd0} - 39'(q[30:0]);
      return m[38:31];
   endfunction

   // 255 * max(s, 0) >> 15
   function automatic logic [7:0] sun_rise(input logic signed [15:0] s);
      logic [14:0] p;
      logic [22:0] m;
      p = s[15] ? 15'd0 : s[14:0];
      m = {p, 8'd0} - 23'(p);
      return m[22:15];
   endfunction

   // 255 * (32768 - max(s, 0)) >> 15, clamped to 255
   function automatic logic [7:0] sun_fall(input logic signed [15:0] s);
      logic [14:0] p;
      logic [15:0] w;
      logic [23:0] m;
      p = s[15] ? 15'd0 : s[14:0];
      w = 16'd32768 - 16'(p);
      m = {w, 8'd0} - 24'(w);
      return m[23] ? 8'hFF : m[22:15];
   endfunction

endpackage

`default_nettype wire

[design/icm_sine_rom.sv]
// quarter-wave sine rom with one registered read port, signed Q1.15 out of a Q0.16 phase
// depends on icm_pkg
`default_nettype none

module icm_sine_rom import icm_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [15:0]        phase,
   output      logic signed [15:0] sine
);

   localparam int AW = $clog2(SINE_TABLE_DEPTH);

   wire [14:0] rom_tab [0:SINE_TABLE_DEPTH];

   // table of sin(pi/2 * k / depth) from a Q2.30 series, rounded and capped
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam longint unsigned X  = (PI_Q30 * 64'(k)) / 64'(2 * SINE_TABLE_DEPTH);
      localparam longint unsigned T1 = ((((X * X) >> 30) * X) >> 30) / 64'd6;
      localparam longint unsigned T2 = ((((T1 * X) >> 30) * X) >> 30) / 64'd20;
      localparam longint unsigned T3 = ((((T2 * X) >> 30) * X) >> 30) / 64'd42;
      localparam longint unsigned T4 = ((((T3 * X) >> 30) * X) >> 30) / 64'd72;
      localparam longint unsigned T5 = ((((T4 * X) >> 30) * X) >> 30) / 64'd110;
      localparam longint unsigned T6 = ((((T5 * X) >> 30) * X) >> 30) / 64'd156;
      localparam longint unsigned T7 = ((((T6 * X) >> 30) * X) >> 30) / 64'd210;
      localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
      localparam longint unsigned POS = (SUM < 0) ? 64'd0 : 64'(SUM);
      localparam longint unsigned V   = (POS + 64'd16384) >> 15;
      assign rom_tab[k] = (V > 64'd32767) ? 15'd32767 : 15'(V);
   end

   logic [AW+1:0] rom_word;
   logic [AW:0]   rom_addr;
   logic [14:0]   mag_ff;
   logic          neg_ff;

   // quadrant folds the address and sets the sign
   always_comb begin
      rom_word = phase[15 -: AW+2];
      if (rom_word[AW]) begin
         rom_addr = (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, rom_word[AW-1:0]};
      end else begin
         rom_addr = {1'b0, rom_word[AW-1:0]};
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= rom_tab[rom_addr];
         neg_ff <= rom_word[AW+1];
      end
   end

   assign sine = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

endmodule

`default_nettype wire

[design/icm_divider.sv]
// pipelined restoring division: count modulo palette size, then the Q0.16 phase
// and the grayscale level, one bit per stage; depends on icm_pkg
`default_nettype none

module icm_divider import icm_pkg::*; #(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int MAX_PALETTE = DEF_MAX_PALETTE
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire icm_tag_type                  in_tag,
   input  wire logic [COUNT_WIDTH-1:0]       in_count,
   input  wire logic [$clog2(MAX_PALETTE+1)-1:0] n,
   output      icm_tag_type                  out_tag,
   output      logic [15:0]                  out_phase,
   output      logic [7:0]                   out_gray
);

   localparam int NW = $clog2(MAX_PALETTE + 1);
   localparam int GW = NW + 8;
   localparam int TS = 16;

   // modulo stages
   logic [COUNT_WIDTH:0]   md_valid_ff;
   logic                   md_inside_ff [0:COUNT_WIDTH];
   logic [NW-1:0]          md_rem_ff    [0:COUNT_WIDTH];
   logic [COUNT_WIDTH-1:0] md_cnt_ff    [0:COUNT_WIDTH];
   logic [NW:0]            md_shift     [0:COUNT_WIDTH-1];
   logic [NW-1:0]          md_rem_in    [0:COUNT_WIDTH-1];

   // phase and gray stages
   logic [TS:0]   dv_valid_ff;
   logic          dv_inside_ff [0:TS];
   logic [NW-1:0] dv_rem_ff    [0:TS];
   logic [GW-1:0] dv_num_ff    [0:TS];
   logic [15:0]   dv_q_ff      [0:TS];
   logic [7:0]    dv_g_ff      [0:TS];
   logic [NW:0]   dv_shift     [0:TS-1];
   logic [NW-1:0] dv_rem_in    [0:TS-1];
   logic [15:0]   dv_q_in      [0:TS-1];
   logic [GW-1:0] dv_num_in    [0:TS-1];
   logic [7:0]    dv_g_in      [0:TS-1];
   logic [GW-1:0] dv_dsh       [0:TS-1];

   logic [NW-1:0] nm1;
   logic [NW-1:0] idx;

   assign nm1 = n - NW'(1);
   assign idx = md_rem_ff[COUNT_WIDTH];

   // one remainder bit per stage
   always_comb begin
      for (int k = 0; k < COUNT_WIDTH; k++) begin
         md_shift[k] = {md_rem_ff[k], md_cnt_ff[k][COUNT_WIDTH-1-k]};
         if (md_shift[k] >= {1'b0, n}) begin
            md_rem_in[k] = NW'(md_shift[k] - {1'b0, n});
         end else begin
            md_rem_in[k] = NW'(md_shift[k]);
         end
      end
   end

   // one phase bit per stage, gray level bits in the first eight
   always_comb begin
      for (int j = 0; j < TS; j++) begin
         dv_shift[j] = {dv_rem_ff[j], 1'b0};
         if (dv_shift[j] >= {1'b0, n}) begin
            dv_rem_in[j] = NW'(dv_shift[j] - {1'b0, n});
            dv_q_in[j]   = {dv_q_ff[j][14:0], 1'b1};
         end else begin
            dv_rem_in[j] = NW'(dv_shift[j]);
            dv_q_in[j]   = {dv_q_ff[j][14:0], 1'b0};
         end
         dv_dsh[j]    = '0;
         dv_num_in[j] = dv_num_ff[j];
         dv_g_in[j]   = dv_g_ff[j];
         if (j < 8) begin
            dv_dsh[j] = GW'(nm1) << (7 - j);
            if (dv_num_ff[j] >= dv_dsh[j]) begin
               dv_num_in[j] = dv_num_ff[j] - dv_dsh[j];
               dv_g_in[j]   = dv_g_ff[j] | (8'd1 << (7 - j));
            end
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         md_valid_ff <= '0;
         dv_valid_ff <= '0;
      end else if (adv) begin
         md_valid_ff <= {md_valid_ff[COUNT_WIDTH-1:0], in_tag.valid};
         dv_valid_ff <= {dv_valid_ff[TS-1:0], md_valid_ff[COUNT_WIDTH]};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         md_rem_ff[0]    <= '0;
         md_cnt_ff[0]    <= in_count;
         md_inside_ff[0] <= in_tag.in_set;
         for (int k = 0; k < COUNT_WIDTH; k++) begin
            md_rem_ff[k+1]    <= md_rem_in[k];
            md_cnt_ff[k+1]    <= md_cnt_ff[k];
            md_inside_ff[k+1] <= md_inside_ff[k];
         end
         dv_rem_ff[0]    <= idx;
         dv_num_ff[0]    <= {idx, 8'd0} - GW'(idx);
         dv_q_ff[0]      <= '0;
         dv_g_ff[0]      <= '0;
         dv_inside_ff[0] <= md_inside_ff[COUNT_WIDTH];
         for (int j = 0; j < TS; j++) begin
            dv_rem_ff[j+1]    <= dv_rem_in[j];
            dv_num_ff[j+1]    <= dv_num_in[j];
            dv_q_ff[j+1]      <= dv_q_in[j];
            dv_g_ff[j+1]      <= dv_g_in[j];
            dv_inside_ff[j+1] <= dv_inside_ff[j];
         end
      end
   end

   assign out_tag.valid  = dv_valid_ff[TS];
   assign out_tag.in_set = dv_inside_ff[TS];
   assign out_phase      = dv_q_ff[TS];
   assign out_gray       = dv_g_ff[TS];

endmodule

`default_nettype wire

[design/iteration_count_color_mapper.sv]
// top level of the iteration count color mapper: registers, divider, sine roms, color stage
// depends on icm_pkg, icm_divider and icm_sine_rom
//
// Usage: each request on req_ carries one escape iteration count and gives one result
// on rsp_ with red, green, blue and inside_set. A count at or above max_iterations
// gives black with inside_set high. Otherwise the count modulo palette_length picks
// a palette entry that is computed on the fly in the selected mode.
// Pipeline: the result reaches rsp_ through COUNT_WIDTH + 1 modulo stages (capture plus
// one per count bit), seventeen phase division stages (load plus one per phase bit),
// the sine rom read and the output register, the first loaded at the edge that accepts
// the request.
// Throughput is one request per cycle; the stages advance together, so a stalled
// result holds the whole pipeline and req_stall is high while rsp_valid and
// rsp_stall are both high.
// Registers are written on csr_ (index 0 max_iterations, 1 palette_length, 2 palette_mode);
// the user must write them only while no request is in flight; the block itself does not
// enforce it. csr_ready is always high. Reset clears all stage valid bits and loads the
// register defaults (100, 256, rainbow). The sine table is a constant rom and needs no fill.
`default_nettype none

module iteration_count_color_mapper import icm_pkg::*; #(
   parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH,
   parameter int MAX_PALETTE      = DEF_MAX_PALETTE,
   parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [COUNT_WIDTH-1:0] req_iteration_count,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [7:0]             rsp_red,
   output      logic [7:0]             rsp_green,
   output      logic [7:0]             rsp_blue,
   output      logic                   rsp_inside_set,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int NW  = $clog2(MAX_PALETTE + 1);
   localparam int WW  = (NW > LEN_W) ? NW : LEN_W;
   localparam int CMW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   logic [15:0]       max_iterations_ff;
   logic [LEN_W-1:0]  palette_length_ff;
   logic [MODE_W-1:0] palette_mode_ff;

   logic              adv;
   logic [WW-1:0]     len_w;
   logic [WW-1:0]     n_w;
   logic [NW-1:0]     n;
   icm_tag_type       in_tag;
   icm_tag_type       dv_tag;
   logic [15:0]       dv_phase;
   logic [7:0]        dv_gray;

   logic [15:0]       base;
   logic [15:0]       phase_r;
   logic [15:0]       phase_g;
   logic [15:0]       phase_b;
   logic signed [15:0] sine_r;
   logic signed [15:0] sine_g;
   logic signed [15:0] sine_b;

   logic              rd_valid_ff;
   logic              rd_inside_ff;
   logic [7:0]        rd_gray_ff;

   logic [7:0]        red_in;
   logic [7:0]        green_in;
   logic [7:0]        blue_in;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_red_ff;
   logic [7:0]        rsp_green_ff;
   logic [7:0]        rsp_blue_ff;
   logic              rsp_inside_ff;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iterations_ff <= RST_MAX_ITER;
         palette_length_ff <= RST_PAL_LEN;
         palette_mode_ff   <= RST_PAL_MODE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_ITER: max_iterations_ff <= csr_data;
            CSR_PAL_LEN:  palette_length_ff <= csr_data[LEN_W-1:0];
            CSR_PAL_MODE: palette_mode_ff   <= csr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output slot is free or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // palette size clamped to 2..MAX_PALETTE
   always_comb begin
      len_w = WW'(palette_length_ff);
      if (len_w < WW'(2)) begin
         n_w = WW'(2);
      end else if (len_w > WW'(MAX_PALETTE)) begin
         n_w = WW'(MAX_PALETTE);
      end else begin
         n_w = len_w;
      end
      n = NW'(n_w);
   end

   // inside test on the incoming count
   assign in_tag.valid  = req_valid;
   assign in_tag.in_set = CMW'(req_iteration_count) >= CMW'(max_iterations_ff);

   icm_divider #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .MAX_PALETTE (MAX_PALETTE)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_tag    (in_tag),
      .in_count  (req_iteration_count),
      .n         (n),
      .out_tag   (dv_tag),
      .out_phase (dv_phase),
      .out_gray  (dv_gray)
   );

   // phases per mode
   always_comb begin
      base = (palette_mode_ff > MODE_OCEAN) ? dv_phase + HALF_TURN : dv_phase;
      if (palette_mode_ff == MODE_SUNSET) begin
         phase_r = {1'b0, dv_phase[15:1]};
         phase_g = {2'b0, dv_phase[15:2]};
         phase_b = dv_phase;
      end else begin
         phase_r = base;
         phase_g = base + THIRD_TURN;
         phase_b = base + TWO_THIRDS_TURN;
      end
   end

   icm_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_r (
      .clock (clock), .en (adv), .phase (phase_r), .sine (sine_r)
   );

   icm_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_g (
      .clock (clock), .en (adv), .phase (phase_g), .sine (sine_g)
   );

   icm_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_b (
      .clock (clock), .en (adv), .phase (phase_b), .sine (sine_b)
   );

   // side data next to the rom read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff <= dv_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_inside_ff <= dv_tag.in_set;
         rd_gray_ff   <= dv_gray;
      end
   end

   // channel formulas
   always_comb begin
      priority if (rd_inside_ff) begin
         red_in   = 8'd0;
         green_in = 8'd0;
         blue_in  = 8'd0;
      end else if (palette_mode_ff == MODE_GRAY) begin
         red_in   = rd_gray_ff;
         green_in = rd_gray_ff;
         blue_in  = rd_gray_ff;
      end else if (palette_mode_ff == MODE_SUNSET) begin
         red_in   = sun_rise(sine_r);
         green_in = sun_rise(sine_g);
         blue_in  = sun_fall(sine_r);
      end else if (palette_mode_ff == MODE_OCEAN) begin
         red_in   = wave_ocean(sine_r);
         green_in = wave_ocean(sine_g);
         blue_in  = wave_ocean(sine_b);
      end else begin
         red_in   = wave_half(sine_r);
         green_in = wave_half(sine_g);
         blue_in  = wave_half(sine_b);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff    <= red_in;
         rsp_green_ff  <= green_in;
         rsp_blue_ff   <= blue_in;
         rsp_inside_ff <= rd_inside_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_inside_set = rsp_inside_ff;

`ifndef SYNTHESIS
   // an inside pixel is always black
   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_set |-> rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0)
      else $error("inside pixel not black");

   // grayscale gives equal channels
   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && palette_mode_ff == MODE_GRAY |-> rsp_red == rsp_green && rsp_green == rsp_blue)
      else $error("grayscale channels differ");

   // a held result keeps the request side stalled and the result unchanged
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall ##1 rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_inside_set))
      else $error("pipeline moved under a stalled result");
`endif

endmodule

`default_nettype wire

[sim/iteration_count_color_mapper_tb.sv]
// testbench of the iteration count color mapper: random and directed pixel counts
// under several register settings, checked against a built-in color predictor
// depends on icm_pkg and iteration_count_color_mapper
`default_nettype none

module iteration_count_color_mapper_tb import icm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEF_SINE_DEPTH;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_set;
   } pixel_color_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [15:0]            req_iteration_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_red, rsp_green, rsp_blue;
   logic                   rsp_inside_set;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // register copies used by the predictor
   logic [15:0]       cfg_max_iter = RST_MAX_ITER;
   logic [LEN_W-1:0]  cfg_pal_len  = RST_PAL_LEN;
   logic [MODE_W-1:0] cfg_mode     = RST_PAL_MODE;

   logic [15:0]     pending_counts[$];
   pixel_color_type expected_colors[$];
   int              errors = 0;
   int              colors_seen = 0;
   bit              calm = 1'b0;
   bit              held_once = 1'b0;
   int              hold_left = 0;
   logic [15:0]     quarter_sine[DEPTH+1];

   iteration_count_color_mapper DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_iteration_count(req_iteration_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_inside_set(rsp_inside_set),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // quarter-wave sine in Q1.15 from a Q2.30 series
   initial begin
      longint unsigned x, term, v;
      longint          sum;
      for (int k = 0; k <= DEPTH; k++) begin
         x = (PI_Q30 * longint'(k)) / (2 * DEPTH);
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (longint'(sum) + 16384) >> 15;
         if (v > 32767) v = 32767;
         quarter_sine[k] = v[15:0];
      end
   end

   function automatic longint sine_of_turn(input logic [15:0] phase);
      longint unsigned a, quad, off;
      longint          mag;
      a = (longint'(phase) * 4 * DEPTH) >> 16;
      quad = a / DEPTH;
      off = a % DEPTH;
      mag = (quad % 2 == 1) ? quarter_sine[DEPTH - off] : quarter_sine[off];
      return (quad >= 2) ? -mag : mag;
   endfunction

   function automatic logic [7:0] sat8(input longint v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] rainbow_level(input logic [15:0] phase);
      return sat8((255 * (32768 + sine_of_turn(phase))) >>> 16);
   endfunction

   function automatic logic [7:0] ocean_level(input logic [15:0] phase);
      longint q;
      q = 19661 * sine_of_turn(phase) + (longint'(1) << 30);
      if (q < 0) q = 0;
      return sat8((255 * q) >>> 31);
   endfunction

   // color of one pixel under the current register copies
   function automatic pixel_color_type color_of_count(input logic [15:0] count);
      pixel_color_type c;
      longint n, idx, s1, s2;
      logic [15:0] t, base;
      c = '0;
      if (count >= cfg_max_iter) begin
         c.in_set = 1'b1;
         return c;
      end
      n = cfg_pal_len;
      if (n < 2) n = 2;
      if (n > DEF_MAX_PALETTE) n = DEF_MAX_PALETTE;
      idx = count % n;
      t = 16'((idx << 16) / n);
      case (cfg_mode)
         MODE_GRAY: begin
            c.red = sat8((255 * idx) / (n - 1));
            c.green = c.red;
            c.blue = c.red;
         end
         MODE_SUNSET: begin
            s1 = sine_of_turn(t >> 1);
            s2 = sine_of_turn(t >> 2);
            if (s1 < 0) s1 = 0;
            if (s2 < 0) s2 = 0;
            c.red = sat8((255 * s1) >>> 15);
            c.green = sat8((255 * s2) >>> 15);
            c.blue = sat8((255 * (32768 - s1)) >>> 15);
         end
         MODE_OCEAN: begin
            c.red = ocean_level(t);
            c.green = ocean_level(t + THIRD_TURN);
            c.blue = ocean_level(t + TWO_THIRDS_TURN);
         end
         default: begin
            base = (cfg_mode == MODE_RAINBOW) ? t : t + HALF_TURN;
            c.red = rainbow_level(base);
            c.green = rainbow_level(base + THIRD_TURN);
            c.blue = rainbow_level(base + TWO_THIRDS_TURN);
         end
      endcase
      return c;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_colors.push_back(color_of_count(req_iteration_count));
         if (!req_valid || !req_stall) begin
            if (pending_counts.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
               req_valid <= 1'b1;
               req_iteration_count <= pending_counts.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random stalls and one long hold-off
   always @(posedge clock) begin
      pixel_color_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            colors_seen++;
            if (expected_colors.size() == 0) begin
               $error("unexpected result red=%0d green=%0d blue=%0d inside=%0b",
                      rsp_red, rsp_green, rsp_blue, rsp_inside_set);
               errors++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_red !== want.red) begin
                  $error("red expected %0d actual %0d", want.red, rsp_red);
                  errors++;
               end
               if (rsp_green !== want.green) begin
                  $error("green expected %0d actual %0d", want.green, rsp_green);
                  errors++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue expected %0d actual %0d", want.blue, rsp_blue);
                  errors++;
               end
               if (rsp_inside_set !== want.in_set) begin
                  $error("inside_set expected %0b actual %0b", want.in_set, rsp_inside_set);
                  errors++;
               end
            end
         end
         if (!held_once && colors_seen >= 150) begin
            held_once <= 1'b1;
            hold_left <= 300;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 21);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_ITER: cfg_max_iter = value;
         CSR_PAL_LEN: cfg_pal_len = value[LEN_W-1:0];
         CSR_PAL_MODE: cfg_mode = value[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_counts.size() != 0 || req_valid || expected_colors.size() != 0);
      repeat (50) @(posedge clock);
   endtask

   // phases of register settings and their pixel counts
   initial begin
      logic [15:0] max_set[12] = '{100, 65535, 0, 1, 300, 65535, 5000, 40000,
                                   65535, 2, 1000, 65535};
      logic [15:0] len_set[12] = '{256, 4096, 17, 0, 1, 8191, 3, 4095,
                                   2, 100, 7, 256};
      logic [15:0] mode_set[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 16'hFFF9, 2, 3, 0};
      logic [15:0] cnt;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset defaults first, with field extremes
      foreach (pending_counts[i]) ;
      pending_counts = '{16'd0, 16'd65535, 16'd99, 16'd100, 16'd255, 16'd256, 16'd1};
      wait_idle();
      write_reg(CSR_UNUSED, 16'hFFFF);
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(CSR_MAX_ITER, max_set[ph]);
         write_reg(CSR_PAL_LEN, len_set[ph]);
         write_reg(CSR_PAL_MODE, mode_set[ph]);
         calm = (ph == 4);
         pending_counts.push_back(16'd0);
         pending_counts.push_back(max_set[ph] == 0 ? 16'd0 : max_set[ph] - 16'd1);
         pending_counts.push_back(16'hFFFF);
         for (int k = 0; k < 65; k++) begin
            if (max_set[ph] > 1 && $urandom_range(3) != 0)
               cnt = 16'($urandom_range(max_set[ph] - 1));
            else
               cnt = 16'($urandom);
            pending_counts.push_back(cnt);
         end
         wait_idle();
      end
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
